### src/gn2o_pkg.sv
// ----------------------------------------------------------------------------
// gn2o_pkg
// Shared widths, constants, register codes and divider handshake types for
// the 2-D gradient noise octave unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gn2o_pkg;

  // Fixed-point format and table geometry
  localparam int FRAC_BITS   = 16;
  localparam int TBL_AW      = 8;
  localparam int MAX_OCTAVES = 8;
  localparam int COORD_W     = 32;
  localparam int NOISE_W     = 20;

  // Internal widths
  localparam int FREQ_W = 32;
  localparam int AMP_W  = 17;
  localparam int ASUM_W = 20;
  localparam int TOT_W  = 27;
  localparam int DVD_W  = TOT_W + FRAC_BITS;
  localparam int DVS_W  = ASUM_W;
  localparam int DIV_CW = $clog2(DVD_W + 1);

  // Register widths and reset values
  localparam int OCT_W  = 4;
  localparam int PERS_W = 17;
  localparam int LAC_W  = 18;
  localparam logic [OCT_W-1:0]  OCT_RST  = 4'd4;
  localparam logic [PERS_W-1:0] PERS_RST = 17'd32768;
  localparam logic [LAC_W-1:0]  LAC_RST  = 18'd131072;

  // Register indexes
  localparam logic [1:0] REG_OCT  = 2'd0;
  localparam logic [1:0] REG_PERS = 2'd1;
  localparam logic [1:0] REG_LAC  = 2'd2;

  // Item codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### src/gn2o_ifs.sv
// ----------------------------------------------------------------------------
// gn2o channel interfaces
// Valid/ready channels for input items and noise results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn2o_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [gn2o_pkg::TBL_AW-1:0]       table_index;
  logic [gn2o_pkg::TBL_AW-1:0]       table_value;
  logic signed [gn2o_pkg::COORD_W-1:0] x_coord;
  logic signed [gn2o_pkg::COORD_W-1:0] y_coord;
  modport source (output valid, op, table_index, table_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, op, table_index, table_value, x_coord, y_coord,
                output ready);
endinterface

interface gn2o_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gn2o_pkg::NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

`default_nettype wire

### src/gradient_noise_2d_octaves_unit.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves_unit
// 2-D improved gradient noise summed over octaves, normalized by the
// amplitude sum. Permutation table held in a 256x8 synchronous memory.
// ----------------------------------------------------------------------------
// Sequencing: a load writes the table entry on its input transfer. A sample
// steps through N octaves in turn (each set by six serial reads of the single
// table port plus the fade and lerp multiplies), then a bit-serial divide.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken.
// Reset: synchronous active-low; table reads as identity until written.
`default_nettype none

module gradient_noise_2d_octaves_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gn2o_in_if.sink          in_ch,
  gn2o_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OCT  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;
  localparam logic [3:0] STEP_LAST = 4'd10;
  localparam int TBL_N = 1 << gn2o_pkg::TBL_AW;
  localparam int ONE   = 1 << gn2o_pkg::FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic [gn2o_pkg::OCT_W-1:0]  oct_cfg_r;
  logic [gn2o_pkg::PERS_W-1:0] pers_cfg_r;
  logic [gn2o_pkg::LAC_W-1:0]  lac_cfg_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r  <= gn2o_pkg::OCT_RST;
      pers_cfg_r <= gn2o_pkg::PERS_RST;
      lac_cfg_r  <= gn2o_pkg::LAC_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        gn2o_pkg::REG_OCT:  oct_cfg_r  <= cfg_pwdata[gn2o_pkg::OCT_W-1:0];
        gn2o_pkg::REG_PERS: pers_cfg_r <= cfg_pwdata[gn2o_pkg::PERS_W-1:0];
        gn2o_pkg::REG_LAC:  lac_cfg_r  <= cfg_pwdata[gn2o_pkg::LAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      gn2o_pkg::REG_OCT:  cfg_prdata = 32'(oct_cfg_r);
      gn2o_pkg::REG_PERS: cfg_prdata = 32'(pers_cfg_r);
      gn2o_pkg::REG_LAC:  cfg_prdata = 32'(lac_cfg_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // clamped settings
  logic [gn2o_pkg::OCT_W-1:0]  oct_n;
  logic [gn2o_pkg::PERS_W-1:0] pers_c;
  always_comb begin
    if (oct_cfg_r == '0) oct_n = gn2o_pkg::OCT_W'(1);
    else if (oct_cfg_r > gn2o_pkg::OCT_W'(gn2o_pkg::MAX_OCTAVES))
      oct_n = gn2o_pkg::OCT_W'(gn2o_pkg::MAX_OCTAVES);
    else oct_n = oct_cfg_r;
    pers_c = (pers_cfg_r > gn2o_pkg::PERS_W'(ONE)) ? gn2o_pkg::PERS_W'(ONE) : pers_cfg_r;
  end

  // ---------------- sequencer state ----------------
  logic [1:0]                        state_r, state_nxt;
  logic [3:0]                        step_r, step_nxt;
  logic [gn2o_pkg::OCT_W-1:0]        oct_r, oct_nxt;
  logic signed [gn2o_pkg::COORD_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic [gn2o_pkg::FREQ_W-1:0]       freq_r, freq_nxt, freq_nx_r, freq_nx_nxt;
  logic [gn2o_pkg::AMP_W-1:0]        amp_r, amp_nxt, amp_nx_r, amp_nx_nxt;
  logic signed [gn2o_pkg::TOT_W-1:0] total_r, total_nxt;
  logic [gn2o_pkg::ASUM_W-1:0]       asum_r, asum_nxt;

  // octave datapath registers
  logic [15:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [gn2o_pkg::TBL_AW-1:0] xi_r, xi_nxt, yi_r, yi_nxt;
  logic [gn2o_pkg::TBL_AW-1:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic [19:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [15:0] cx_r, cx_nxt, cy_r, cy_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [16:0] u_r, u_nxt, v_r, v_nxt;
  logic [1:0]  h00_r, h00_nxt, h10_r, h10_nxt, h01_r, h01_nxt;
  logic signed [18:0] g00_r, g00_nxt, g10_r, g10_nxt, g01_r, g01_nxt, g11_r, g11_nxt;
  logic signed [20:0] ab_r, ab_nxt, cd_r, cd_nxt;
  logic signed [21:0] nv_r, nv_nxt;
  logic signed [gn2o_pkg::NOISE_W-1:0] res_r, res_nxt;

  // output register
  logic                                out_vld_r, out_vld_nxt;
  logic signed [gn2o_pkg::NOISE_W-1:0] out_val_r, out_val_nxt;

  // ---------------- permutation table memory ----------------
  logic [gn2o_pkg::TBL_AW-1:0] mem [TBL_N];
  logic [TBL_N-1:0]            valid_r;
  logic [gn2o_pkg::TBL_AW-1:0] rd_addr, rd_data_r, rd_idx_r, rd_out;
  logic                        rd_vld_r;
  logic                        in_xfer, ld_xfer;

  assign in_xfer = in_ch.valid & in_ch.ready;
  assign ld_xfer = in_xfer & (in_ch.op == gn2o_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (ld_xfer) mem[in_ch.table_index] <= in_ch.table_value;
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  // valid bits: an unwritten entry reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ld_xfer) valid_r[in_ch.table_index] <= 1'b1;
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_out = rd_vld_r ? rd_data_r : rd_idx_r;

  // read address per step
  always_comb begin
    case (step_r)
      4'd1:    rd_addr = xi_r;
      4'd2:    rd_addr = xi_r + 1'b1;
      4'd3:    rd_addr = ha_r;
      4'd4:    rd_addr = hb_r;
      4'd5:    rd_addr = ha_r + 1'b1;
      4'd6:    rd_addr = hb_r + 1'b1;
      default: rd_addr = xi_r;
    endcase
  end

  // ---------------- gradient select ----------------
  function automatic logic signed [18:0] grad(input logic [1:0] h,
                                              input logic signed [17:0] gx,
                                              input logic signed [17:0] gy);
    logic signed [18:0] ex, ey;
    ex = {gx[17], gx};
    ey = {gy[17], gy};
    case (h)
      2'd0:    grad = ex + ey;
      2'd1:    grad = ey - ex;
      2'd2:    grad = ex - ey;
      default: grad = -ex - ey;
    endcase
  endfunction

  // ---------------- divider ----------------
  gn2o_pkg::div_req_t div_req;
  gn2o_pkg::div_rsp_t div_rsp;

  gn2o_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- datapath and control ----------------
  logic signed [64:0] px, py;
  logic signed [21:0] ax, ay;
  logic signed [38:0] tax, tay, bsx, bsy;
  logic [31:0]        sqx, sqy, cpx, cpy;
  logic [35:0]        upx, upy;
  logic [49:0]        fprod;
  logic [33:0]        aprod;
  logic signed [17:0] ddx0, ddx1, ddy0, ddy1;
  logic signed [19:0] dab, dcd;
  logic signed [37:0] pab, pcd, sab, scd;
  logic signed [21:0] dn;
  logic signed [39:0] pn, sn;
  logic signed [39:0] pc, sc;
  logic [gn2o_pkg::TOT_W-1:0] tmag;
  logic signed [gn2o_pkg::TOT_W-1:0] tsum;
  logic [gn2o_pkg::DVD_W-1:0] q;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    oct_nxt     = oct_r;
    xs_nxt      = xs_r;
    ys_nxt      = ys_r;
    freq_nxt    = freq_r;
    amp_nxt     = amp_r;
    freq_nx_nxt = freq_nx_r;
    amp_nx_nxt  = amp_nx_r;
    total_nxt   = total_r;
    asum_nxt    = asum_r;
    fx_nxt = fx_r;  fy_nxt = fy_r;  xi_nxt = xi_r;  yi_nxt = yi_r;
    ha_nxt = ha_r;  hb_nxt = hb_r;
    bx_nxt = bx_r;  by_nxt = by_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  u_nxt = u_r;    v_nxt = v_r;
    h00_nxt = h00_r; h10_nxt = h10_r; h01_nxt = h01_r;
    g00_nxt = g00_r; g10_nxt = g10_r; g01_nxt = g01_r; g11_nxt = g11_r;
    ab_nxt = ab_r;  cd_nxt = cd_r;  nv_nxt = nv_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    out_val_nxt = out_val_r;
    div_req     = '0;

    // octave arithmetic, one non-constant multiply deep per step
    px    = xs_r * $signed({1'b0, freq_r});
    py    = ys_r * $signed({1'b0, freq_r});
    ax    = $signed({6'b0, fx_r}) * 22'sd6 - 22'sd983040;
    ay    = $signed({6'b0, fy_r}) * 22'sd6 - 22'sd983040;
    tax   = $signed({23'b0, fx_r}) * ax;
    tay   = $signed({23'b0, fy_r}) * ay;
    bsx   = (tax >>> gn2o_pkg::FRAC_BITS) + 39'sd655360;
    bsy   = (tay >>> gn2o_pkg::FRAC_BITS) + 39'sd655360;
    sqx   = fx_r * fx_r;
    sqy   = fy_r * fy_r;
    cpx   = cx_r * fx_r;
    cpy   = cy_r * fy_r;
    upx   = dx_r * bx_r;
    upy   = dy_r * by_r;
    fprod = freq_r * lac_cfg_r;
    aprod = amp_r * pers_c;
    ddx0  = $signed({2'b0, fx_r});
    ddy0  = $signed({2'b0, fy_r});
    ddx1  = ddx0 - 18'sd65536;
    ddy1  = ddy0 - 18'sd65536;
    dab   = {g10_r[18], g10_r} - {g00_r[18], g00_r};
    dcd   = {g11_r[18], g11_r} - {g01_r[18], g01_r};
    pab   = $signed({1'b0, u_r}) * dab;
    pcd   = $signed({1'b0, u_r}) * dcd;
    sab   = (pab >>> gn2o_pkg::FRAC_BITS) + 38'(g00_r);
    scd   = (pcd >>> gn2o_pkg::FRAC_BITS) + 38'(g01_r);
    dn    = {cd_r[20], cd_r} - {ab_r[20], ab_r};
    pn    = $signed({1'b0, v_r}) * dn;
    sn    = (pn >>> gn2o_pkg::FRAC_BITS) + 40'(ab_r);
    pc    = nv_r * $signed({1'b0, amp_r});
    sc    = pc >>> gn2o_pkg::FRAC_BITS;
    tsum  = total_r + sc[gn2o_pkg::TOT_W-1:0];
    tmag  = tsum[gn2o_pkg::TOT_W-1] ? gn2o_pkg::TOT_W'(-tsum) : gn2o_pkg::TOT_W'(tsum);
    q     = div_rsp.quot;

    // output register drains independently
    if (out_vld_r && out_ch.ready) out_vld_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_ch.op == gn2o_pkg::OP_SAMPLE) begin
          xs_nxt    = in_ch.x_coord;
          ys_nxt    = in_ch.y_coord;
          freq_nxt  = gn2o_pkg::FREQ_W'(ONE);
          amp_nxt   = gn2o_pkg::AMP_W'(ONE);
          total_nxt = '0;
          asum_nxt  = '0;
          oct_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_OCT;
        end
      end
      ST_OCT: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          4'd0: begin
            fx_nxt = px[31:16];
            fy_nxt = py[31:16];
            xi_nxt = px[39:32];
            yi_nxt = py[39:32];
          end
          4'd1: begin
            bx_nxt      = bsx[19:0];
            by_nxt      = bsy[19:0];
            cx_nxt      = sqx[31:16];
            cy_nxt      = sqy[31:16];
            freq_nx_nxt = fprod[47:16];
            amp_nx_nxt  = aprod[32:16];
          end
          4'd2: begin
            ha_nxt = rd_out + yi_r;
            dx_nxt = cpx[31:16];
            dy_nxt = cpy[31:16];
          end
          4'd3: begin
            hb_nxt = rd_out + yi_r;
            u_nxt  = upx[32:16];
            v_nxt  = upy[32:16];
          end
          4'd4: h00_nxt = rd_out[1:0];
          4'd5: h10_nxt = rd_out[1:0];
          4'd6: h01_nxt = rd_out[1:0];
          4'd7: begin
            g00_nxt = grad(h00_r, ddx0, ddy0);
            g10_nxt = grad(h10_r, ddx1, ddy0);
            g01_nxt = grad(h01_r, ddx0, ddy1);
            g11_nxt = grad(rd_out[1:0], ddx1, ddy1);
          end
          4'd8: begin
            ab_nxt = sab[20:0];
            cd_nxt = scd[20:0];
          end
          4'd9: nv_nxt = sn[21:0];
          STEP_LAST: begin
            total_nxt = tsum;
            asum_nxt  = asum_r + gn2o_pkg::ASUM_W'(amp_r);
            amp_nxt   = amp_nx_r;
            freq_nxt  = freq_nx_r;
            step_nxt  = '0;
            if (oct_r == oct_n - 1'b1) begin
              div_req.start    = 1'b1;
              div_req.neg      = tsum[gn2o_pkg::TOT_W-1];
              div_req.dividend = {tmag, gn2o_pkg::FRAC_BITS'(0)};
              div_req.divisor  = asum_r + gn2o_pkg::ASUM_W'(amp_r);
              state_nxt        = ST_DIV;
            end else begin
              oct_nxt = oct_r + 1'b1;
            end
          end
          default: step_nxt = '0;
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // saturate to the output range
          if (!div_rsp.neg) begin
            if (q > gn2o_pkg::DVD_W'(524287)) res_nxt = 20'sd524287;
            else res_nxt = $signed(q[gn2o_pkg::NOISE_W-1:0]);
          end else begin
            if (q > gn2o_pkg::DVD_W'(524288)) res_nxt = -20'sd524288;
            else res_nxt = -$signed(q[gn2o_pkg::NOISE_W-1:0]);
          end
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_val_nxt = res_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      oct_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      oct_r     <= oct_nxt;
      out_vld_r <= out_vld_nxt;
    end
    xs_r <= xs_nxt;  ys_r <= ys_nxt;
    freq_r <= freq_nxt;  amp_r <= amp_nxt;
    freq_nx_r <= freq_nx_nxt;  amp_nx_r <= amp_nx_nxt;
    total_r <= total_nxt;  asum_r <= asum_nxt;
    fx_r <= fx_nxt;  fy_r <= fy_nxt;  xi_r <= xi_nxt;  yi_r <= yi_nxt;
    ha_r <= ha_nxt;  hb_r <= hb_nxt;
    bx_r <= bx_nxt;  by_r <= by_nxt;  cx_r <= cx_nxt;  cy_r <= cy_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;  u_r <= u_nxt;    v_r <= v_nxt;
    h00_r <= h00_nxt; h10_r <= h10_nxt; h01_r <= h01_nxt;
    g00_r <= g00_nxt; g10_r <= g10_nxt; g01_r <= g01_nxt; g11_r <= g11_nxt;
    ab_r <= ab_nxt;  cd_r <= cd_nxt;  nv_r <= nv_nxt;
    res_r <= res_nxt;
    out_val_r <= out_val_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.noise_value = out_val_r;

  // ---------------- assertions ----------------
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE)
    else $error("input taken while busy");

  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OCT |-> oct_r < oct_n)
    else $error("octave counter past limit");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside divide phase");

  a_push_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && (!out_vld_r || out_ch.ready)) |=> out_vld_r)
    else $error("result lost on push");

endmodule

`default_nettype wire

### src/gn2o_div.sv
// ----------------------------------------------------------------------------
// gn2o_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2o_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gn2o_pkg::div_req_t req,
  output gn2o_pkg::div_rsp_t      rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           neg_r, neg_nxt;
  logic [gn2o_pkg::DIV_CW-1:0]    cnt_r, cnt_nxt;
  logic [gn2o_pkg::DVD_W-1:0]     q_r, q_nxt;
  logic [gn2o_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [gn2o_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [gn2o_pkg::DVS_W:0]       trial;
  logic [gn2o_pkg::DVS_W:0]       diff;

  // one restoring step
  always_comb begin
    trial    = {rem_r, q_r[gn2o_pkg::DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.neg;
      cnt_nxt  = gn2o_pkg::DIV_CW'(gn2o_pkg::DVD_W);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[gn2o_pkg::DVS_W-1:0];
        q_nxt   = {q_r[gn2o_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[gn2o_pkg::DVS_W-1:0];
        q_nxt   = {q_r[gn2o_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == gn2o_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire
